// File: hw/rtl/vlbf_pkg.sv
// Shared types, register codes and saturation helper for the voice
// low-pass / biquad filter. No dependencies.
package vlbf_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 16;
  // width of the shifted sums handed to the saturation helper
  localparam int unsigned SatInW = 22;

  typedef enum logic [CfgIdxW-1:0] {
    RegEnables = 4'd0,
    RegLpGain  = 4'd1,
    RegLpFb    = 4'd2,
    RegBqB0    = 4'd3,
    RegBqB1    = 4'd4,
    RegBqB2    = 4'd5,
    RegBqA1    = 4'd6,
    RegBqA2    = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]                 enables;  // bit0 low-pass, bit1 biquad
    logic [SampleW-1:0]         lp_gain;  // unsigned Q15
    logic signed [SampleW-1:0]  lp_fb;
    logic signed [SampleW-1:0]  bq_b0;
    logic signed [SampleW-1:0]  bq_b1;
    logic signed [SampleW-1:0]  bq_b2;
    logic signed [SampleW-1:0]  bq_a1;
    logic signed [SampleW-1:0]  bq_a2;
  } cfg_t;

  // Clamp a signed value to the 16-bit sample range.
  function automatic logic signed [SampleW-1:0] sat16(logic signed [SatInW-1:0] v);
    logic ovf;
    ovf = !((&v[SatInW-1:SampleW-1]) || !(|v[SatInW-1:SampleW-1]));
    if (ovf) begin
      sat16 = v[SatInW-1] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      sat16 = v[SampleW-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/vlbf_cfg_regs.sv
// Configuration register file of the voice filter.
// Depends on vlbf_pkg for the register codes and the cfg_t bundle.
module vlbf_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vlbf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vlbf_pkg::CfgDataW-1:0] cfg_data_i,
  output vlbf_pkg::cfg_t                cfg_o
);

  vlbf_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (vlbf_pkg::cfg_reg_e'(cfg_index_i))
        vlbf_pkg::RegEnables: cfg_d.enables = cfg_data_i[1:0];
        vlbf_pkg::RegLpGain:  cfg_d.lp_gain = cfg_data_i;
        vlbf_pkg::RegLpFb:    cfg_d.lp_fb   = cfg_data_i;
        vlbf_pkg::RegBqB0:    cfg_d.bq_b0   = cfg_data_i;
        vlbf_pkg::RegBqB1:    cfg_d.bq_b1   = cfg_data_i;
        vlbf_pkg::RegBqB2:    cfg_d.bq_b2   = cfg_data_i;
        vlbf_pkg::RegBqA1:    cfg_d.bq_a1   = cfg_data_i;
        vlbf_pkg::RegBqA2:    cfg_d.bq_a2   = cfg_data_i;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enables: 2'b00, lp_gain: 16'h8000, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/vlbf_lowpass.sv
// One-pole low-pass stage with its output history register.
// Depends on vlbf_pkg for widths and saturation.
module vlbf_lowpass (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                enable_i,
  input  logic                                commit_i,
  input  logic [vlbf_pkg::SampleW-1:0]        gain_i,
  input  logic signed [vlbf_pkg::SampleW-1:0] fb_i,
  input  logic signed [vlbf_pkg::SampleW-1:0] sample_i,
  output logic signed [vlbf_pkg::SampleW-1:0] sample_o
);

  logic signed [vlbf_pkg::SampleW-1:0] prev_q, prev_d;
  logic signed [32:0] prod_gain;
  logic signed [31:0] prod_fb;
  logic signed [33:0] acc;
  logic signed [vlbf_pkg::SampleW-1:0] filt;

  assign prod_gain = $signed({1'b0, gain_i}) * sample_i;
  assign prod_fb   = fb_i * prev_q;
  assign acc       = {prod_gain[32], prod_gain} + {{2{prod_fb[31]}}, prod_fb};
  // arithmetic shift by 15 gives the floor
  assign filt      = vlbf_pkg::sat16({{3{acc[33]}}, acc[33:15]});

  assign sample_o = enable_i ? filt : sample_i;

  always_comb begin
    prev_d = prev_q;
    if (commit_i && enable_i) begin
      prev_d = filt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

// File: hw/rtl/vlbf_biquad.sv
// Direct form 1 biquad stage with its input and output history.
// Depends on vlbf_pkg for the cfg_t bundle, widths and saturation.
module vlbf_biquad (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                enable_i,
  input  logic                                commit_i,
  input  vlbf_pkg::cfg_t                      cfg_i,
  input  logic signed [vlbf_pkg::SampleW-1:0] sample_i,
  output logic signed [vlbf_pkg::SampleW-1:0] sample_o
);

  logic signed [vlbf_pkg::SampleW-1:0] x1_q, x1_d, x2_q, x2_d;
  logic signed [vlbf_pkg::SampleW-1:0] y1_q, y1_d, y2_q, y2_d;
  logic signed [31:0] p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [34:0] acc;
  logic signed [36:0] scaled;
  logic [15:0]        rnd;
  logic signed [37:0] rounded;
  logic signed [vlbf_pkg::SampleW-1:0] filt;

  assign p_b0 = cfg_i.bq_b0 * sample_i;
  assign p_b1 = cfg_i.bq_b1 * x1_q;
  assign p_b2 = cfg_i.bq_b2 * x2_q;
  assign p_a1 = cfg_i.bq_a1 * y1_q;
  assign p_a2 = cfg_i.bq_a2 * y2_q;

  assign acc = {{3{p_b0[31]}}, p_b0} + {{3{p_b1[31]}}, p_b1} + {{3{p_b2[31]}}, p_b2}
             + {{3{p_a1[31]}}, p_a1} + {{3{p_a2[31]}}, p_a2};
  assign scaled  = {acc, 2'b00};
  // round half toward the even result bit
  assign rnd     = scaled[16] ? 16'h8000 : 16'h7FFF;
  assign rounded = {scaled[36], scaled} + {22'd0, rnd};
  assign filt    = vlbf_pkg::sat16(rounded[37:16]);

  assign sample_o = enable_i ? filt : sample_i;

  always_comb begin
    x1_d = x1_q;
    x2_d = x2_q;
    y1_d = y1_q;
    y2_d = y2_q;
    if (commit_i && enable_i) begin
      x2_d = x1_q;
      x1_d = sample_i;
      y2_d = y1_q;
      y1_d = filt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else begin
      x1_q <= x1_d;
      x2_q <= x2_d;
      y1_q <= y1_d;
      y2_q <= y2_d;
    end
  end

endmodule

// File: hw/rtl/voice_lowpass_biquad_filter_unit.sv
// Voice filter: each 16-bit signed sample word runs through an optional one-pole
// low-pass and then an optional direct form 1 biquad, each saturated to 16 bits;
// tlast is carried along unchanged. The unit takes one word per clock while
// m_axis_tready does not hold it back, and has three register stages (input,
// low-pass result, biquad result); a word passes through them in that order
// and shows on the master side from the biquad result register. Each filter's
// feedback loop closes inside its own stage. Write coefficients and enables
// only while no word is in flight. Depends on vlbf_pkg and the stage modules.
module voice_lowpass_biquad_filter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] sample_in
  input  logic                          s_axis_tlast,   // frame_last_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // [15:0] sample_out
  output logic                          m_axis_tlast,   // frame_last_out
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vlbf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vlbf_pkg::CfgDataW-1:0] cfg_data_i
);

  vlbf_pkg::cfg_t cfg;

  logic in_valid_q, in_valid_d, mid_valid_q, mid_valid_d, out_valid_q, out_valid_d;
  logic in_ready, mid_ready, out_ready;
  logic mid_adv, out_adv;
  logic signed [vlbf_pkg::SampleW-1:0] in_sample_q, mid_sample_q, out_sample_q;
  logic in_last_q, mid_last_q, out_last_q;
  logic signed [vlbf_pkg::SampleW-1:0] lp_sample, bq_sample;

  vlbf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // each stage frees up when it is empty or its word moves on
  assign out_ready = !out_valid_q || m_axis_tready;
  assign mid_ready = !mid_valid_q || out_ready;
  assign in_ready  = !in_valid_q || mid_ready;
  assign mid_adv   = in_valid_q && mid_ready;
  assign out_adv   = mid_valid_q && out_ready;

  assign s_axis_tready = in_ready;

  vlbf_lowpass u_lp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .enable_i (cfg.enables[0]),
    .commit_i (mid_adv),
    .gain_i   (cfg.lp_gain),
    .fb_i     (cfg.lp_fb),
    .sample_i (in_sample_q),
    .sample_o (lp_sample)
  );

  vlbf_biquad u_bq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .enable_i (cfg.enables[1]),
    .commit_i (out_adv),
    .cfg_i    (cfg),
    .sample_i (mid_sample_q),
    .sample_o (bq_sample)
  );

  always_comb begin
    in_valid_d  = in_ready  ? s_axis_tvalid : in_valid_q;
    mid_valid_d = mid_ready ? in_valid_q    : mid_valid_q;
    out_valid_d = out_ready ? mid_valid_q   : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      mid_valid_q <= mid_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && in_ready) begin
      in_sample_q <= s_axis_tdata;
      in_last_q   <= s_axis_tlast;
    end
    if (mid_adv) begin
      mid_sample_q <= lp_sample;
      mid_last_q   <= in_last_q;
    end
    if (out_adv) begin
      out_sample_q <= bq_sample;
      out_last_q   <= mid_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tlast  = out_last_q;

endmodule
